### hdl/rdvam_pkg.sv
// ----------------------------------------------------------------------------
// rdvam_pkg
// Shared codes, defaults and types for the rendezvous address map.
// ----------------------------------------------------------------------------
package rdvam_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int ADDR_BITS_DEF   = 64;

  // Fixed field widths of the stream words.
  localparam int WEIGHT_W  = 32;
  localparam int BLOCK_W   = 64;
  localparam int BIT_CNT_W = 6;   // counts the block number bits
  localparam int IDX_OUT_W = 6;
  localparam int CNT_OUT_W = 7;
  localparam int VERSION_W = 64;
  localparam int ADDR_OUT_W = 64;

  // Command codes.
  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_RV    = 3'd1;
  localparam logic [2:0] CMD_BLOCK = 3'd2;
  localparam logic [2:0] CMD_NTH   = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Operations of the shared arithmetic unit.
  typedef enum logic {
    UOP_SCORE,   // low 32 bits of a * b
    UOP_MOD      // one restoring step of a remainder
  } unit_op_e;

  typedef struct packed {
    unit_op_e              op;
    logic [WEIGHT_W-1:0]   a;
    logic [WEIGHT_W-1:0]   b;
    logic                  shift_in;
  } unit_req_t;

endpackage

### hdl/rdvam_store.sv
// ----------------------------------------------------------------------------
// rdvam_store
// Entry memories: address and weight, one write and one registered read port.
// ----------------------------------------------------------------------------
module rdvam_store #(
  parameter int MAX_ENTRIES = rdvam_pkg::MAX_ENTRIES_DEF,
  parameter int ADDR_BITS   = rdvam_pkg::ADDR_BITS_DEF,
  localparam int IW         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [IW-1:0]                 wr_idx_i,
  input  logic [ADDR_BITS-1:0]          wr_addr_i,
  input  logic [rdvam_pkg::WEIGHT_W-1:0] wr_weight_i,
  input  logic                          rd_en_i,
  input  logic [IW-1:0]                 rd_idx_i,
  output logic [ADDR_BITS-1:0]          rd_addr_o,
  output logic [rdvam_pkg::WEIGHT_W-1:0] rd_weight_o
);

  logic [ADDR_BITS-1:0]           addr_mem [MAX_ENTRIES];
  logic [rdvam_pkg::WEIGHT_W-1:0] weight_mem [MAX_ENTRIES];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      addr_mem[wr_idx_i]   <= wr_addr_i;
      weight_mem[wr_idx_i] <= wr_weight_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_addr_o   <= addr_mem[rd_idx_i];
      rd_weight_o <= weight_mem[rd_idx_i];
    end
  end

endmodule

### hdl/rdvam_unit.sv
// ----------------------------------------------------------------------------
// rdvam_unit
// Shared arithmetic unit: 32x32 score multiply or one remainder step.
// ----------------------------------------------------------------------------
module rdvam_unit #(
  parameter int CNT_W = 7
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  rdvam_pkg::unit_req_t           req_i,
  output logic [rdvam_pkg::WEIGHT_W-1:0] result_o
);

  logic [rdvam_pkg::WEIGHT_W-1:0] score;
  logic [CNT_W:0]                 trial;
  logic [CNT_W:0]                 divisor;
  logic [CNT_W:0]                 rem;
  logic [rdvam_pkg::WEIGHT_W-1:0] res_d;

  // score: low word of the product
  assign score = req_i.a * req_i.b;

  // shift one dividend bit into the remainder, subtract if it fits
  always_comb begin
    trial   = {req_i.a[CNT_W-1:0], req_i.shift_in};
    divisor = {1'b0, req_i.b[CNT_W-1:0]};
    rem     = (trial >= divisor) ? (trial - divisor) : trial;
  end

  always_comb begin
    unique case (req_i.op)
      rdvam_pkg::UOP_SCORE: res_d = score;
      rdvam_pkg::UOP_MOD:   res_d = rdvam_pkg::WEIGHT_W'(rem[CNT_W-1:0]);
      default:              res_d = score;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_o <= res_d;
    end
  end

endmodule

### hdl/rendezvous_address_map_core.sv
// ----------------------------------------------------------------------------
// rendezvous_address_map_core
// Versioned device address table with rendezvous, block and nth lookup.
// ----------------------------------------------------------------------------
// One command word is taken at a time and answered by exactly one result
// word; the input is not ready until the previous command has been handed to
// the output register, which may still hold an untaken result. Add, clear,
// unknown commands and any lookup on an empty table pass from decode straight
// to done; an nth lookup in range reads its entry first. Rendezvous lookup reads
// one entry per cycle from the weight memory through the shared multiplier and
// compare. Block lookup runs a restoring remainder of the 64-bit block number
// by the entry count, one bit per cycle on the shared unit. The memories need no
// clearing after reset; only entries below the count are ever read.
module rendezvous_address_map_core #(
  parameter int MAX_ENTRIES = rdvam_pkg::MAX_ENTRIES_DEF,
  parameter int ADDR_BITS   = rdvam_pkg::ADDR_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // command words
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] address, [95:64] entry_weight, [127:96] key_hash,
  // [191:128] block_number, [197:192] entry_index
  input  logic [199:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]   s_axis_tuser,
  // result words
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] address_out, [69:64] index_out, [76:70] entry_count,
  // [140:77] map_version
  output logic [143:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]   m_axis_tuser
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int WW = rdvam_pkg::WEIGHT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_MOD    = 3'd3;
  localparam logic [2:0] S_MODEND = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_FETCH  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q;

  // captured command
  logic [2:0]                    cmd_q;
  logic [ADDR_BITS-1:0]          addr_in_q;
  logic [WW-1:0]                 weight_q;
  logic [WW-1:0]                 key_q;
  logic [rdvam_pkg::BLOCK_W-1:0] blk_q;
  logic [5:0]                    nth_q;

  // map state
  logic [CW-1:0]                   count_q;
  logic [rdvam_pkg::VERSION_W-1:0] version_q;

  // scan and remainder bookkeeping
  logic [CW-1:0]                   scan_q;
  logic                            p1_v_q;
  logic                            p2_v_q;
  logic [IW-1:0]                   p1_idx_q;
  logic [IW-1:0]                   p2_idx_q;
  logic [WW-1:0]                   best_q;
  logic [IW-1:0]                   sel_q;
  logic [rdvam_pkg::BIT_CNT_W-1:0] bit_cnt_q;
  logic                            mod_first_q;

  // pending result
  logic [1:0]                       res_status_q;
  logic [rdvam_pkg::ADDR_OUT_W-1:0] res_addr_q;
  logic [rdvam_pkg::IDX_OUT_W-1:0]  res_idx_q;

  // output register
  logic                             m_valid_q;
  logic [1:0]                       m_status_q;
  logic [rdvam_pkg::ADDR_OUT_W-1:0] m_addr_q;
  logic [rdvam_pkg::IDX_OUT_W-1:0]  m_idx_q;
  logic [rdvam_pkg::CNT_OUT_W-1:0]  m_count_q;
  logic [rdvam_pkg::VERSION_W-1:0]  m_version_q;

  // memory and unit hookup
  logic                 wr_en;
  logic                 rd_en;
  logic [IW-1:0]        rd_idx;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [WW-1:0]        rd_weight;
  logic                 unit_en;
  rdvam_pkg::unit_req_t unit_req;
  logic [WW-1:0]        unit_res;

  logic full;
  logic add_ok;
  logic scan_more;
  logic nth_ok;
  logic s_accept;
  logic out_free;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign full          = (count_q == CW'(MAX_ENTRIES));
  assign add_ok        = (cmd_q == rdvam_pkg::CMD_ADD) && !full;
  assign scan_more     = (scan_q < count_q);
  assign nth_ok        = (32'(nth_q) < 32'(count_q));

  rdvam_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_idx_i    (count_q[IW-1:0]),
    .wr_addr_i   (addr_in_q),
    .wr_weight_i (weight_q),
    .rd_en_i     (rd_en),
    .rd_idx_i    (rd_idx),
    .rd_addr_o   (rd_addr),
    .rd_weight_o (rd_weight)
  );

  rdvam_unit #(
    .CNT_W (CW)
  ) u_unit (
    .clk_i    (clk_i),
    .en_i     (unit_en),
    .req_i    (unit_req),
    .result_o (unit_res)
  );

  // memory and unit control per state
  always_comb begin
    wr_en             = 1'b0;
    rd_en             = 1'b0;
    rd_idx            = sel_q;
    unit_en           = 1'b0;
    unit_req.op       = rdvam_pkg::UOP_SCORE;
    unit_req.a        = key_q;
    unit_req.b        = rd_weight;
    unit_req.shift_in = 1'b0;
    unique case (state_q)
      S_DECODE: begin
        wr_en = add_ok;
      end
      S_SCAN: begin
        rd_en   = scan_more;
        rd_idx  = scan_q[IW-1:0];
        unit_en = p1_v_q;
      end
      S_MOD: begin
        unit_en           = 1'b1;
        unit_req.op       = rdvam_pkg::UOP_MOD;
        unit_req.a        = mod_first_q ? '0 : unit_res;
        unit_req.b        = WW'(count_q);
        unit_req.shift_in = blk_q[rdvam_pkg::BLOCK_W-1];
      end
      S_READ: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      version_q <= '0;
      p1_v_q    <= 1'b0;
      p2_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      // output valid: load on a finished command, drop when taken
      if ((state_q == S_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          p1_v_q <= 1'b0;
          p2_v_q <= 1'b0;
          unique case (cmd_q)
            rdvam_pkg::CMD_ADD: begin
              state_q <= S_DONE;
              if (!full) begin
                count_q   <= count_q + CW'(1);
                version_q <= version_q + 64'd1;
              end
            end
            rdvam_pkg::CMD_RV: begin
              state_q <= (count_q != '0) ? S_SCAN : S_DONE;
            end
            rdvam_pkg::CMD_BLOCK: begin
              state_q <= (count_q != '0) ? S_MOD : S_DONE;
            end
            rdvam_pkg::CMD_NTH: begin
              state_q <= nth_ok ? S_READ : S_DONE;
            end
            rdvam_pkg::CMD_CLEAR: begin
              state_q   <= S_DONE;
              count_q   <= '0;
              version_q <= version_q + 64'd1;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          p1_v_q <= scan_more;
          p2_v_q <= p1_v_q;
          if (!scan_more && !p1_v_q && !p2_v_q) begin
            state_q <= S_READ;
          end
        end
        S_MOD: begin
          if (bit_cnt_q == '1) begin
            state_q <= S_MODEND;
          end
        end
        S_MODEND: state_q <= S_READ;
        S_READ:   state_q <= S_FETCH;
        S_FETCH:  state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          cmd_q     <= s_axis_tuser;
          addr_in_q <= s_axis_tdata[ADDR_BITS-1:0];
          weight_q  <= s_axis_tdata[95:64];
          key_q     <= s_axis_tdata[127:96];
          blk_q     <= s_axis_tdata[191:128];
          nth_q     <= s_axis_tdata[197:192];
        end
      end
      S_DECODE: begin
        scan_q      <= '0;
        best_q      <= '0;
        bit_cnt_q   <= '0;
        mod_first_q <= 1'b1;
        sel_q       <= (cmd_q == rdvam_pkg::CMD_NTH) ? IW'(nth_q) : '0;
        // add reports its slot or full, clear reports ok, the rest report not found until a lookup finds an entry
        if (cmd_q == rdvam_pkg::CMD_CLEAR) begin
          res_status_q <= rdvam_pkg::ST_OK;
        end else if (cmd_q == rdvam_pkg::CMD_ADD) begin
          res_status_q <= full ? rdvam_pkg::ST_FULL : rdvam_pkg::ST_OK;
        end else begin
          res_status_q <= rdvam_pkg::ST_NOTFOUND;
        end
        res_addr_q <= add_ok ? rdvam_pkg::ADDR_OUT_W'(addr_in_q) : '0;
        res_idx_q  <= add_ok ? rdvam_pkg::IDX_OUT_W'(count_q) : '0;
      end
      S_SCAN: begin
        if (scan_more) begin
          scan_q <= scan_q + CW'(1);
        end
        p1_idx_q <= scan_q[IW-1:0];
        p2_idx_q <= p1_idx_q;
        // first strict maximum wins
        if (p2_v_q && (unit_res > best_q)) begin
          best_q <= unit_res;
          sel_q  <= p2_idx_q;
        end
      end
      S_MOD: begin
        blk_q       <= blk_q << 1;
        bit_cnt_q   <= bit_cnt_q + rdvam_pkg::BIT_CNT_W'(1);
        mod_first_q <= 1'b0;
      end
      S_MODEND: sel_q <= unit_res[IW-1:0];
      S_FETCH: begin
        res_status_q <= rdvam_pkg::ST_OK;
        res_addr_q   <= rdvam_pkg::ADDR_OUT_W'(rd_addr);
        res_idx_q    <= rdvam_pkg::IDX_OUT_W'(sel_q);
      end
      S_DONE: begin
        if (out_free) begin
          m_status_q  <= res_status_q;
          m_addr_q    <= res_addr_q;
          m_idx_q     <= res_idx_q;
          m_count_q   <= rdvam_pkg::CNT_OUT_W'(count_q);
          m_version_q <= version_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {3'b000, m_version_q, m_count_q, m_idx_q, m_addr_q};

  // one command at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready)
    else $error("input taken while a command is in flight");

  // table never overfills
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_ENTRIES)
    else $error("entry count above capacity");

  // version only steps by one
  a_version_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (version_q == $past(version_q)) || (version_q == $past(version_q) + 64'd1))
    else $error("version jumped");

  // scan pipeline only lives inside the scan
  a_scan_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_v_q || p2_v_q) |-> (state_q == S_SCAN))
    else $error("scan pipeline busy outside scan");

endmodule

### bench/rendezvous_address_map_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rendezvous_address_map_core_tb
// Self-checking bench for the rendezvous address map core. A short table of
// directed commands covers the empty, out-of-range and unknown-command
// cases. It is followed by random fill/lookup/clear episodes. Every result word is
// checked field by field against a behavioral model of the map or a hand-written
// result, while both stream sides stall at random.
// ----------------------------------------------------------------------------
module rendezvous_address_map_core_tb;

  localparam int NUM_ENTRIES  = 64;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 120;

  // One command word as the bench sees it
  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] addr;
    logic [31:0] weight;
    logic [31:0] key;
    logic [63:0] blk;
    logic [5:0]  nth;
  } cmd_item_t;

  // One result word
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] addr;
    logic [5:0]  idx;
    logic [6:0]  cnt;
    logic [63:0] ver;
  } map_result_t;

  // Directed row: command plus an optional hand-written result
  typedef struct packed {
    cmd_item_t   item;
    bit          typed;
    map_result_t res;
  } stim_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  // Model state of the map
  logic [63:0]  tbl_addr [NUM_ENTRIES];
  logic [31:0]  tbl_weight [NUM_ENTRIES];
  int unsigned  tbl_count;
  logic [63:0]  tbl_version;

  map_result_t  pending_results[$];
  stim_row_t    dir_rows[$];
  int unsigned  fail_count;
  int unsigned  cycle_count;
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;

  rendezvous_address_map_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Map model: applies one command, returns the result word it should give
  function automatic map_result_t apply_command(input cmd_item_t it);
    map_result_t r;
    logic [31:0] best;
    logic [31:0] score;
    int unsigned pick;
    r = '0;
    r.status = rdvam_pkg::ST_NOTFOUND;
    case (it.cmd)
      rdvam_pkg::CMD_ADD: begin
        if (tbl_count >= NUM_ENTRIES) begin
          r.status = rdvam_pkg::ST_FULL;
        end else begin
          tbl_addr[tbl_count]   = it.addr;
          tbl_weight[tbl_count] = it.weight;
          r.status = rdvam_pkg::ST_OK;
          r.addr   = it.addr;
          r.idx    = tbl_count[5:0];
          tbl_count   = tbl_count + 1;
          tbl_version = tbl_version + 64'd1;
        end
      end
      rdvam_pkg::CMD_RV: begin
        if (tbl_count > 0) begin
          best = '0;
          pick = 0;
          // first strict maximum of key * weight, low 32 bits
          for (int unsigned i = 0; i < tbl_count; i++) begin
            score = it.key * tbl_weight[i];
            if (score > best) begin
              best = score;
              pick = i;
            end
          end
          r.status = rdvam_pkg::ST_OK;
          r.addr   = tbl_addr[pick];
          r.idx    = pick[5:0];
        end
      end
      rdvam_pkg::CMD_BLOCK: begin
        if (tbl_count > 0) begin
          pick = int'(it.blk % 64'(tbl_count));
          r.status = rdvam_pkg::ST_OK;
          r.addr   = tbl_addr[pick];
          r.idx    = pick[5:0];
        end
      end
      rdvam_pkg::CMD_NTH: begin
        if (it.nth < tbl_count) begin
          r.status = rdvam_pkg::ST_OK;
          r.addr   = tbl_addr[it.nth];
          r.idx    = it.nth;
        end
      end
      rdvam_pkg::CMD_CLEAR: begin
        tbl_count   = 0;
        tbl_version = tbl_version + 64'd1;
        r.status    = rdvam_pkg::ST_OK;
      end
      default: ;
    endcase
    r.cnt = tbl_count[6:0];
    r.ver = tbl_version;
    return r;
  endfunction

  function automatic cmd_item_t mk_item(input logic [2:0] cmd, input logic [63:0] addr,
                                        input logic [31:0] weight, input logic [31:0] key,
                                        input logic [63:0] blk, input logic [5:0] nth);
    return {cmd, addr, weight, key, blk, nth};
  endfunction

  function automatic map_result_t mk_res(input logic [1:0] st, input logic [63:0] addr,
                                         input logic [5:0] idx, input logic [6:0] cnt,
                                         input logic [63:0] ver);
    return {st, addr, idx, cnt, ver};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Weights and keys lean toward zero, powers of two and small values so
  // that zero scores and ties show up often
  function automatic logic [31:0] pick_word32();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // Present one command word with a random lead-in gap, wait for the
  // handshake, then queue the result it should give
  task automatic send_command(input cmd_item_t it, input bit typed, input map_result_t typed_res);
    map_result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {2'b00, it.nth, it.blk, it.key, it.weight, it.addr};
    s_axis_tuser  = it.cmd;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_command(it);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  // Random episodes: optional clear, fill toward a target count with
  // lookups mixed in, then start over
  task automatic run_random(input int unsigned n_items);
    cmd_item_t   it;
    int unsigned target;
    int unsigned episode_left;
    int unsigned r;
    episode_left = 0;
    target       = 0;
    for (int unsigned k = 0; k < n_items; k++) begin
      it.addr   = ($urandom_range(0, 9) == 0) ? {64{$urandom_range(0, 1) == 1}} : rand64();
      it.weight = pick_word32();
      it.key    = pick_word32();
      case ($urandom_range(0, 3))
        0: it.blk = 64'($urandom_range(0, 200));
        1: it.blk = {64{$urandom_range(0, 1) == 1}};
        default: it.blk = rand64();
      endcase
      if (tbl_count > 0 && $urandom_range(0, 9) < 7)
        it.nth = 6'($urandom_range(0, tbl_count - 1));
      else
        it.nth = 6'($urandom_range(0, 63));
      r = $urandom_range(0, 99);
      if (episode_left == 0) begin
        target       = ($urandom_range(0, 3) == 0) ? NUM_ENTRIES : $urandom_range(1, 16);
        episode_left = 2 * target + $urandom_range(10, 30);
        it.cmd       = (r < 80) ? rdvam_pkg::CMD_CLEAR : rdvam_pkg::CMD_ADD;
      end else if (r < 3) begin
        it.cmd = 3'($urandom_range(5, 7));
      end else if (r < 5) begin
        it.cmd = rdvam_pkg::CMD_CLEAR;
      end else if ((tbl_count < target && r < 60) || r < 12) begin
        it.cmd = rdvam_pkg::CMD_ADD;
      end else begin
        case ($urandom_range(0, 2))
          0: it.cmd = rdvam_pkg::CMD_RV;
          1: it.cmd = rdvam_pkg::CMD_BLOCK;
          default: it.cmd = rdvam_pkg::CMD_NTH;
        endcase
      end
      if (episode_left > 0) episode_left--;
      send_command(it, 1'b0, '0);
    end
  endtask

  task automatic report_mismatch(input string fld, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
    $display("%0t ns: %s mismatch, expected %h actual %h", $time, fld, exp_v, act_v);
    fail_count++;
  endtask

  // Result checker, samples on the rising edge
  always @(posedge clk_i) begin
    map_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none actual %h/%h",
                 $time, m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tuser !== exp_r.status)
          report_mismatch("status", 64'(exp_r.status), 64'(m_axis_tuser));
        if (m_axis_tdata[63:0] !== exp_r.addr)
          report_mismatch("address_out", exp_r.addr, m_axis_tdata[63:0]);
        if (m_axis_tdata[69:64] !== exp_r.idx)
          report_mismatch("index_out", 64'(exp_r.idx), 64'(m_axis_tdata[69:64]));
        if (m_axis_tdata[76:70] !== exp_r.cnt)
          report_mismatch("entry_count", 64'(exp_r.cnt), 64'(m_axis_tdata[76:70]));
        if (m_axis_tdata[140:77] !== exp_r.ver)
          report_mismatch("map_version", exp_r.ver, m_axis_tdata[140:77]);
      end
    end
  end

  // Receiver back-pressure, changes on the falling edge
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rendezvous_address_map_core verification failed");
      $finish;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = rdvam_pkg::CMD_ADD;
    m_axis_tready = 1'b0;
    fail_count    = 0;
    cycle_count   = 0;
    tbl_count     = 0;
    tbl_version   = '0;
    tx_idle_pct   = 20;
    rx_idle_pct   = 79;

    // Directed rows; typed results are the obvious ones
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_RV, '0, '0, 32'h1, '0, '0), 1'b1,
                        mk_res(rdvam_pkg::ST_NOTFOUND, '0, '0, 7'd0, 64'd0)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_BLOCK, '0, '0, '0, 64'd5, '0), 1'b1,
                        mk_res(rdvam_pkg::ST_NOTFOUND, '0, '0, 7'd0, 64'd0)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_NTH, '0, '0, '0, '0, 6'd0), 1'b1,
                        mk_res(rdvam_pkg::ST_NOTFOUND, '0, '0, 7'd0, 64'd0)});
    // clear on an empty map still bumps the version
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_CLEAR, '0, '0, '0, '0, '0), 1'b1,
                        mk_res(rdvam_pkg::ST_OK, '0, '0, 7'd0, 64'd1)});
    // unknown commands leave everything alone
    for (int c = 5; c <= 7; c++)
      dir_rows.push_back({mk_item(3'(c), '1, '1, '1, '1, '1), 1'b1,
                          mk_res(rdvam_pkg::ST_NOTFOUND, '0, '0, 7'd0, 64'd1)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_ADD, '1, 32'hFFFF_FFFF, '0, '0, '0), 1'b1,
                        mk_res(rdvam_pkg::ST_OK, '1, 6'd0, 7'd1, 64'd2)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_ADD, '0, 32'h0, '1, '1, '1), 1'b1,
                        mk_res(rdvam_pkg::ST_OK, '0, 6'd1, 7'd2, 64'd3)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_ADD, 64'h0123_4567_89AB_CDEF, 32'h8000_0000,
                                '0, '0, '0),
                        1'b1, mk_res(rdvam_pkg::ST_OK, 64'h0123_4567_89AB_CDEF, 6'd2, 7'd3,
                                     64'd4)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_ADD, 64'h5555_5555_5555_5555, 32'h1,
                                '0, '0, '0), 1'b1,
                        mk_res(rdvam_pkg::ST_OK, 64'h5555_5555_5555_5555, 6'd3, 7'd4,
                               64'd5)});
    // key zero: every score zero, entry 0 wins
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_RV, '0, '0, 32'h0, '0, '0), 1'b1,
                        mk_res(rdvam_pkg::ST_OK, '1, 6'd0, 7'd4, 64'd5)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_RV, '0, '0, 32'hFFFF_FFFF, '0, '0), 1'b0,
                        map_result_t'('0)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_RV, '0, '0, 32'h2, '0, '0), 1'b0,
                        map_result_t'('0)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_RV, '0, '0, 32'h8000_0000, '0, '0), 1'b0,
                        map_result_t'('0)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_BLOCK, '0, '0, '0, '1, '0), 1'b0,
                        map_result_t'('0)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_BLOCK, '0, '0, '0, 64'd0, '0), 1'b1,
                        mk_res(rdvam_pkg::ST_OK, '1, 6'd0, 7'd4, 64'd5)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_BLOCK, '0, '0, '0, 64'd7, '0), 1'b0,
                        map_result_t'('0)});
    // nth bounds: top index, index equal to count, last valid index
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_NTH, '0, '0, '0, '0, 6'd63), 1'b1,
                        mk_res(rdvam_pkg::ST_NOTFOUND, '0, '0, 7'd4, 64'd5)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_NTH, '0, '0, '0, '0, 6'd4), 1'b1,
                        mk_res(rdvam_pkg::ST_NOTFOUND, '0, '0, 7'd4, 64'd5)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_NTH, '0, '0, '0, '0, 6'd3), 1'b1,
                        mk_res(rdvam_pkg::ST_OK, 64'h5555_5555_5555_5555, 6'd3, 7'd4,
                               64'd5)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_CLEAR, '1, '1, '1, '1, '1), 1'b1,
                        mk_res(rdvam_pkg::ST_OK, '0, '0, 7'd0, 64'd6)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_NTH, '0, '0, '0, '0, 6'd0), 1'b1,
                        mk_res(rdvam_pkg::ST_NOTFOUND, '0, '0, 7'd0, 64'd6)});
    dir_rows.push_back({mk_item(rdvam_pkg::CMD_ADD, 64'h8000_0000_0000_0001, 32'h1234_5678,
                                '0, '0, '0),
                        1'b0, map_result_t'('0)});

    // Hold reset, release on a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_command(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    // Random part in three stall profiles
    run_random(142);
    tx_idle_pct = 79;
    rx_idle_pct = 20;
    run_random(142);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(142);
    s_axis_tvalid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("rendezvous_address_map_core verification clean");
    end else begin
      $display("rendezvous_address_map_core verification failed");
    end
    $finish;
  end

endmodule
